// ===== design/gdff_pkg.sv =====
// Shared types, codes and neighbor tables of the grid distance flood fill.
package gdff_pkg;

   localparam int DIST_W = 5;
   localparam int COORD_W = 6;
   localparam int CSR_DATA_W = 7;
   localparam int CSR_INDEX_W = 1;

   localparam logic [DIST_W-1:0] UNREACHED = 5'd31;
   localparam logic [CSR_DATA_W-1:0] SIZE_RESET = 7'd64;

   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_FLOOD = 2'd1;
   localparam logic [1:0] REQ_READ = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLS = 1'b1;

   localparam logic [1:0] OFS_MINUS = 2'd0;
   localparam logic [1:0] OFS_ZERO = 2'd1;
   localparam logic [1:0] OFS_PLUS = 2'd2;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic               blocked_in;
   } gdff_req_type;

   typedef struct packed {
      logic              status;
      logic              reached;
      logic [DIST_W-1:0] distance;
   } gdff_rsp_type;

   // Neighbors are visited row by row: the row above, the same row, the row below.
   function automatic logic [1:0] nbr_row_ofs(input logic [2:0] n);
      logic [1:0] ofs;
      case (n) inside
         [3'd0:3'd2]: ofs = OFS_MINUS;
         [3'd3:3'd4]: ofs = OFS_ZERO;
         default: ofs = OFS_PLUS;
      endcase
      return ofs;
   endfunction

   function automatic logic [1:0] nbr_col_ofs(input logic [2:0] n);
      logic [1:0] ofs;
      case (n) inside
         3'd0, 3'd3, 3'd5: ofs = OFS_MINUS;
         3'd1, 3'd6: ofs = OFS_ZERO;
         default: ofs = OFS_PLUS;
      endcase
      return ofs;
   endfunction

endpackage

// ===== design/gdff_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gdff_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/grid_distance_flood_fill_top.sv =====
// Top level of the grid distance flood fill: sequencer, size registers and map memories.
//
//   channel   ports                          transfer when
//   --------  -----------------------------  ----------------------------------
//   request   start, busy, req               start high while busy is low
//   result    rsp_strobe, rsp                every cycle rsp_strobe is high
//   config    csr_valid, csr_ready, csr_*    csr_valid and csr_ready both high
//
// Writes, unused codes and out-of-grid requests end in a result transfer straight from the
// execute state, reads from the read-wait state after it. A flood decodes the request,
// marks the used grid unreached and seeds the start cell, then per level scans each cell,
// and for each frontier cell checks each neighbor inside the grid and skips those outside.
// It stops after the first level that reaches nothing new, or at the level limit. After
// reset a clearing pass of all MAX_ROWS*MAX_COLS cells keeps busy high; results cannot stall.
module grid_distance_flood_fill_top
   import gdff_pkg::*;
#(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64,
   parameter int MAX_LEVELS = 20
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  gdff_req_type           req,
   output logic                   rsp_strobe,
   output gdff_rsp_type           rsp,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int CELLS = MAX_ROWS * MAX_COLS;
   localparam int AW = $clog2(CELLS);
   localparam int RW = $clog2(MAX_ROWS);
   localparam int CW = $clog2(MAX_COLS);
   localparam int SRW = $clog2(MAX_ROWS + 1);
   localparam int SCW = $clog2(MAX_COLS + 1);
   localparam logic [AW-1:0] COLS_A = AW'(MAX_COLS);
   localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
   localparam logic [DIST_W-1:0] LAST_LEVEL = DIST_W'(MAX_LEVELS - 1);

   typedef enum logic [9:0] {
      S_CLEAR    = 10'b0000000001,
      S_IDLE     = 10'b0000000010,
      S_EXEC     = 10'b0000000100,
      S_RD_WAIT  = 10'b0000001000,
      S_INIT     = 10'b0000010000,
      S_SEED     = 10'b0000100000,
      S_SCAN     = 10'b0001000000,
      S_SCAN_CHK = 10'b0010000000,
      S_NBR      = 10'b0100000000,
      S_NBR_CHK  = 10'b1000000000
   } state_type;

   function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
      return AW'(r) * COLS_A + AW'(c);
   endfunction

   state_type state_ff, state_in;
   logic [CSR_DATA_W-1:0] rows_ff, rows_in;
   logic [CSR_DATA_W-1:0] cols_ff, cols_in;
   gdff_req_type req_ff, req_in;
   logic rsp_strobe_ff, rsp_strobe_in;
   gdff_rsp_type rsp_ff, rsp_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [RW-1:0] r_ff, r_in;
   logic [CW-1:0] c_ff, c_in;
   logic [2:0] n_ff, n_in;
   logic [DIST_W-1:0] k_ff, k_in;
   logic progress_ff, progress_in;

   logic [SRW-1:0] rows_eff;
   logic [SCW-1:0] cols_eff;
   logic out_of_grid;
   logic r_last, c_last;
   logic [RW-1:0] req_r, nbr_r;
   logic [CW-1:0] req_c, nbr_c;
   logic nbr_row_ok, nbr_col_ok;
   logic [AW-1:0] nbr_addr;

   logic blk_we, blk_wd, blk_rd;
   logic [AW-1:0] blk_wa;
   logic dist_we;
   logic [AW-1:0] dist_wa;
   logic [DIST_W-1:0] dist_wd, dist_rd;
   logic [AW-1:0] rd_addr;
   logic do_step, do_adv;

   gdff_ram #(.WIDTH(1), .DEPTH(CELLS)) u_blocked_ram (
      .clock   (clock),
      .wr_en   (blk_we),
      .wr_addr (blk_wa),
      .wr_data (blk_wd),
      .rd_addr (rd_addr),
      .rd_data (blk_rd)
   );

   gdff_ram #(.WIDTH(DIST_W), .DEPTH(CELLS)) u_distance_ram (
      .clock   (clock),
      .wr_en   (dist_we),
      .wr_addr (dist_wa),
      .wr_data (dist_wd),
      .rd_addr (rd_addr),
      .rd_data (dist_rd)
   );

   // A size of zero acts as one and a size beyond the grid acts as the grid size.
   always_comb begin
      if (rows_ff == '0) begin
         rows_eff = SRW'(1);
      end else if (int'(rows_ff) > MAX_ROWS) begin
         rows_eff = SRW'(MAX_ROWS);
      end else begin
         rows_eff = SRW'(rows_ff);
      end
      if (cols_ff == '0) begin
         cols_eff = SCW'(1);
      end else if (int'(cols_ff) > MAX_COLS) begin
         cols_eff = SCW'(MAX_COLS);
      end else begin
         cols_eff = SCW'(cols_ff);
      end
   end

   assign out_of_grid = (int'(req_ff.row) >= int'(rows_eff)) ||
                        (int'(req_ff.col) >= int'(cols_eff));
   // Only used once the coordinates are known to lie inside the grid.
   assign req_r = RW'(req_ff.row);
   assign req_c = CW'(req_ff.col);
   assign r_last = (SRW'(r_ff) == rows_eff - 1'b1);
   assign c_last = (SCW'(c_ff) == cols_eff - 1'b1);

   // Neighbor n of the current cell and whether it lies inside the used grid.
   always_comb begin
      nbr_r = r_ff;
      nbr_row_ok = 1'b1;
      case (nbr_row_ofs(n_ff))
         OFS_MINUS: begin
            nbr_row_ok = (r_ff != '0);
            nbr_r = r_ff - 1'b1;
         end
         OFS_PLUS: begin
            nbr_row_ok = !r_last;
            nbr_r = r_ff + 1'b1;
         end
         default: begin
         end
      endcase
      nbr_c = c_ff;
      nbr_col_ok = 1'b1;
      case (nbr_col_ofs(n_ff))
         OFS_MINUS: begin
            nbr_col_ok = (c_ff != '0);
            nbr_c = c_ff - 1'b1;
         end
         OFS_PLUS: begin
            nbr_col_ok = !c_last;
            nbr_c = c_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign nbr_addr = cell_addr(nbr_r, nbr_c);

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      rsp_strobe_in = 1'b0;
      rsp_in = rsp_ff;
      clr_in = clr_ff;
      r_in = r_ff;
      c_in = c_ff;
      n_in = n_ff;
      k_in = k_ff;
      progress_in = progress_ff;
      blk_we = 1'b0;
      blk_wa = cell_addr(req_r, req_c);
      blk_wd = req_ff.blocked_in;
      dist_we = 1'b0;
      dist_wa = cell_addr(r_ff, c_ff);
      dist_wd = UNREACHED;
      rd_addr = cell_addr(r_ff, c_ff);
      do_step = 1'b0;
      do_adv = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            blk_we = 1'b1;
            blk_wa = clr_ff;
            blk_wd = 1'b0;
            dist_we = 1'b1;
            dist_wa = clr_ff;
            dist_wd = UNREACHED;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_CELL) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               req_in = req;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            rsp_in = '0;
            case (req_ff.req_type)
               REQ_WRITE: begin
                  if (out_of_grid) begin
                     rsp_in.status = 1'b1;
                  end else begin
                     blk_we = 1'b1;
                  end
                  rsp_strobe_in = 1'b1;
                  state_in = S_IDLE;
               end
               REQ_FLOOD: begin
                  if (out_of_grid) begin
                     rsp_in.status = 1'b1;
                     rsp_strobe_in = 1'b1;
                     state_in = S_IDLE;
                  end else begin
                     r_in = '0;
                     c_in = '0;
                     state_in = S_INIT;
                  end
               end
               REQ_READ: begin
                  if (out_of_grid) begin
                     rsp_in.status = 1'b1;
                     rsp_strobe_in = 1'b1;
                     state_in = S_IDLE;
                  end else begin
                     rd_addr = cell_addr(req_r, req_c);
                     state_in = S_RD_WAIT;
                  end
               end
               default: begin
                  // The unused request code does nothing and reports success.
                  rsp_strobe_in = 1'b1;
                  state_in = S_IDLE;
               end
            endcase
         end
         S_RD_WAIT: begin
            rsp_in = '0;
            if (dist_rd != UNREACHED) begin
               rsp_in.reached = 1'b1;
               rsp_in.distance = dist_rd;
            end
            rsp_strobe_in = 1'b1;
            state_in = S_IDLE;
         end
         S_INIT: begin
            dist_we = 1'b1;
            if (c_last) begin
               c_in = '0;
               if (r_last) begin
                  state_in = S_SEED;
               end else begin
                  r_in = r_ff + 1'b1;
               end
            end else begin
               c_in = c_ff + 1'b1;
            end
         end
         S_SEED: begin
            dist_we = 1'b1;
            dist_wa = cell_addr(req_r, req_c);
            dist_wd = '0;
            r_in = '0;
            c_in = '0;
            k_in = '0;
            progress_in = 1'b0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (dist_rd == k_ff) begin
               n_in = '0;
               state_in = S_NBR;
            end else begin
               do_adv = 1'b1;
            end
         end
         S_NBR: begin
            if (nbr_row_ok && nbr_col_ok) begin
               rd_addr = nbr_addr;
               state_in = S_NBR_CHK;
            end else begin
               do_step = 1'b1;
            end
         end
         S_NBR_CHK: begin
            if (!blk_rd && dist_rd == UNREACHED) begin
               dist_we = 1'b1;
               dist_wa = nbr_addr;
               dist_wd = k_ff + 1'b1;
               progress_in = 1'b1;
            end
            do_step = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (do_step) begin
         if (n_ff == 3'd7) begin
            do_adv = 1'b1;
         end else begin
            n_in = n_ff + 1'b1;
            state_in = S_NBR;
         end
      end

      // Move on to the next cell of the sweep; at the end of the grid the level closes.
      if (do_adv) begin
         state_in = S_SCAN;
         if (c_last) begin
            c_in = '0;
            if (r_last) begin
               r_in = '0;
               if (!progress_in || k_ff == LAST_LEVEL) begin
                  rsp_in = '0;
                  rsp_strobe_in = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  k_in = k_ff + 1'b1;
                  progress_in = 1'b0;
               end
            end else begin
               r_in = r_ff + 1'b1;
            end
         end else begin
            c_in = c_ff + 1'b1;
         end
      end
   end

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ROWS: rows_in = csr_data;
            CSR_COLS: cols_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         rsp_strobe_ff <= 1'b0;
         rows_ff <= SIZE_RESET;
         cols_ff <= SIZE_RESET;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      r_ff <= r_in;
      c_ff <= c_in;
      n_ff <= n_in;
      k_ff <= k_in;
      progress_ff <= progress_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp = rsp_ff;

endmodule

// ===== design/gdff_checker.sv =====
// Port-level checks of the grid distance flood fill and their binding to the top level.
module gdff_port_checker
   import gdff_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input logic         rsp_strobe,
   input gdff_rsp_type rsp
);

   // An accepted request keeps the block busy until its result.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after a request transfer");

   // A result ends a busy period and frees the block in the same cycle.
   a_result_ends_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (!busy && $past(busy)))
      else $error("result strobe outside the end of a busy period");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp.status || !rsp.reached)) |-> (rsp.distance == '0 &&
      !(rsp.status && rsp.reached)))
      else $error("distance or reached flag set on an error or unreached result");

endmodule

bind grid_distance_flood_fill_top gdff_port_checker u_gdff_port_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp        (rsp)
);
